@@ rtl/core/rog_pkg.sv @@
package rog_pkg;

  // input mode codes
  localparam logic [1:0] MODE_MOVE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // cell state codes
  localparam logic [1:0] CELL_UNKNOWN = 2'd0;
  localparam logic [1:0] CELL_FREE    = 2'd1;
  localparam logic [1:0] CELL_OCC     = 2'd2;
  localparam logic [1:0] CELL_BAD     = 2'd3;

  // occupancy percent values
  localparam logic [6:0] PCT_FREE    = 7'd0;
  localparam logic [6:0] PCT_UNKNOWN = 7'd50;
  localparam logic [6:0] PCT_OCC     = 7'd100;

  // width of a center offset and of a shifted source coordinate
  localparam int DW = 17;
  localparam int SW = 18;

  // classified request kinds
  typedef enum logic [2:0] {
    K_NONE,
    K_MOVE_STAY,
    K_MOVE_SHIFT,
    K_WRITE,
    K_READ
  } kind_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN
  } state_t;

  // classified request passed from front to back
  typedef struct packed {
    kind_t                  kind;
    logic                   in_grid;
    logic [1:0]             value;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
  } cmd_t;

  function automatic logic [6:0] pct_of(input logic [1:0] s);
    logic [6:0] p;
    p = PCT_UNKNOWN;
    if (s == CELL_OCC) p = PCT_OCC;
    else if (s == CELL_FREE) p = PCT_FREE;
    return p;
  endfunction

endpackage

@@ rtl/core/rog_cmd_queue.sv @@
module rog_cmd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         not_full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] head
);

  logic [W-1:0] slots [2];
  logic         wp;
  logic         rp;
  logic [1:0]   count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rp];

  // two-entry ring with occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_data;
  end

endmodule

@@ rtl/core/rog_front.sv @@
module rog_front #(
  parameter int GRID_SIDE = 64,
  parameter int AW = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic signed [15:0]  center_x,
  input  logic signed [15:0]  center_y,
  input  logic [5:0]          cell_x,
  input  logic [5:0]          cell_y,
  input  logic [1:0]          cell_value,
  input  logic                init_done,
  input  logic                q_not_full,
  output logic                q_push,
  output rog_pkg::cmd_t       q_cmd,
  output logic [AW-1:0]       q_idx
);
  import rog_pkg::*;

  logic signed [15:0] last_x;
  logic signed [15:0] last_y;
  logic               accept;

  assign in_ready = init_done && q_not_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // classify the request and form offsets and cell index
  always_comb begin
    q_cmd.dx      = DW'(center_x) - DW'(last_x);
    q_cmd.dy      = DW'(center_y) - DW'(last_y);
    q_cmd.in_grid = (32'(cell_x) < GRID_SIDE) && (32'(cell_y) < GRID_SIDE);
    q_cmd.value   = (cell_value == CELL_BAD) ? CELL_UNKNOWN : cell_value;
    q_idx         = AW'(32'(cell_y) * GRID_SIDE + 32'(cell_x));
    unique case (mode)
      MODE_MOVE: begin
        q_cmd.kind = ((center_x != last_x) || (center_y != last_y)) ? K_MOVE_SHIFT
                                                                     : K_MOVE_STAY;
      end
      MODE_WRITE: q_cmd.kind = K_WRITE;
      MODE_READ:  q_cmd.kind = K_READ;
      default:    q_cmd.kind = K_NONE;
    endcase
  end

  // last center follows accepted moves
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
    end else if (accept && (mode == MODE_MOVE)) begin
      last_x <= center_x;
      last_y <= center_y;
    end
  end

endmodule

@@ rtl/core/rog_back.sv @@
module rog_back #(
  parameter int GRID_SIDE = 64,
  parameter int AW = 12,
  parameter int CW = 6
) (
  input  logic           clk,
  input  logic           rst,
  output logic           init_done,
  input  logic           q_not_empty,
  input  rog_pkg::cmd_t  q_cmd,
  input  logic [AW-1:0]  q_idx,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     read_value,
  output logic [6:0]     occupancy_percent,
  output logic           moved
);
  import rog_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
  localparam logic [CW-1:0] SIDE_MAX = CW'(GRID_SIDE - 1);
  localparam logic signed [SW-1:0] SIDE_S = SW'(GRID_SIDE);

  // grid store
  logic [1:0]     mem [CELLS];
  logic [1:0]     rd_data;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [1:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;

  state_t state;
  state_t state_next;

  // walk registers
  logic [AW-1:0]        k;
  logic [CW-1:0]        x;
  logic [CW-1:0]        y;
  logic [AW-1:0]        off;
  logic                 asc;
  logic signed [DW-1:0] mv_dx;
  logic signed [DW-1:0] mv_dy;
  logic                 wr_pend;
  logic [AW-1:0]        wr_addr;
  logic                 wr_zero;
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic                 src_ok;
  logic                 walk_last;
  logic                 dir_up;

  // response stage between memory and output register
  logic        p_valid;
  kind_t       p_kind;
  logic        p_from_mem;
  logic [1:0]  p_val;
  logic [1:0]  p_state;
  logic        out_adv;
  logic        p_load;

  assign init_done = (state != ST_CLEAR);
  assign out_adv   = !out_valid || out_ready;

  // source cell of the current destination
  assign sx        = SW'(mv_dx) + SW'(x);
  assign sy        = SW'(mv_dy) + SW'(y);
  assign src_ok    = !sx[SW-1] && (sx < SIDE_S) && !sy[SW-1] && (sy < SIDE_S);
  assign walk_last = asc ? (k == LAST_IDX) : (k == '0);
  assign dir_up    = (mv_dy > 0) || ((mv_dy == 0) && (mv_dx > 0));

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // sequencer: next state and memory port control
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    p_load     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wr_addr;
    mem_wdata  = wr_zero ? CELL_UNKNOWN : rd_data;
    mem_re     = 1'b0;
    mem_raddr  = k + off;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = k;
        mem_wdata = CELL_UNKNOWN;
        if (k == LAST_IDX) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (q_not_empty) begin
          if (q_cmd.kind == K_MOVE_SHIFT) begin
            if (!p_valid) begin
              q_pop      = 1'b1;
              state_next = ST_SETUP;
            end
          end else if (!p_valid || out_adv) begin
            q_pop  = 1'b1;
            p_load = 1'b1;
            if (q_cmd.in_grid && (q_cmd.kind == K_WRITE)) begin
              mem_we    = 1'b1;
              mem_waddr = q_idx;
              mem_wdata = q_cmd.value;
            end
            if (q_cmd.in_grid && (q_cmd.kind == K_READ)) begin
              mem_re    = 1'b1;
              mem_raddr = q_idx;
            end
          end
        end
      end
      ST_SETUP: state_next = ST_WALK;
      ST_WALK: begin
        mem_we = wr_pend;
        mem_re = src_ok;
        if (walk_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        mem_we     = wr_pend;
        state_next = ST_RUN;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  // clear sweep and shift walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= (state == ST_WALK);
      case (state)
        ST_CLEAR: k <= k + AW'(1);
        ST_SETUP: begin
          asc <= dir_up;
          k   <= dir_up ? '0 : LAST_IDX;
          x   <= dir_up ? '0 : SIDE_MAX;
          y   <= dir_up ? '0 : SIDE_MAX;
        end
        ST_WALK: begin
          if (asc) begin
            k <= k + AW'(1);
            if (x == SIDE_MAX) begin
              x <= '0;
              y <= y + CW'(1);
            end else begin
              x <= x + CW'(1);
            end
          end else begin
            k <= k - AW'(1);
            if (x == '0) begin
              x <= SIDE_MAX;
              y <= y - CW'(1);
            end else begin
              x <= x - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // offset setup and pending walk write
  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.kind == K_MOVE_SHIFT)) begin
      mv_dx <= q_cmd.dx;
      mv_dy <= q_cmd.dy;
    end
    if (state == ST_SETUP) off <= AW'(32'(mv_dy) * GRID_SIDE + 32'(mv_dx));
    wr_addr <= k;
    wr_zero <= !src_ok;
  end

  // response stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_load || (state == ST_DRAIN)) begin
      p_valid <= 1'b1;
    end else if (out_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_kind     <= q_cmd.kind;
      p_from_mem <= q_cmd.in_grid && (q_cmd.kind == K_READ);
      p_val      <= (q_cmd.in_grid && (q_cmd.kind == K_WRITE)) ? q_cmd.value : CELL_UNKNOWN;
    end else if (state == ST_DRAIN) begin
      p_kind     <= K_MOVE_SHIFT;
      p_from_mem <= 1'b0;
      p_val      <= CELL_UNKNOWN;
    end
  end

  assign p_state = p_from_mem ? rd_data : p_val;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      read_value <= p_state;
      moved      <= (p_kind == K_MOVE_SHIFT);
      case (p_kind) inside
        K_WRITE, K_READ: occupancy_percent <= pct_of(p_state);
        default:         occupancy_percent <= PCT_FREE;
      endcase
    end
  end

endmodule

@@ rtl/core/rolling_occupancy_grid_unit.sv @@
// reads, writes, unchanged moves and unused modes: one item per cycle while the
// output is not stalled; result via queue, response stage, output register
// a move to a new center walks all GRID_SIDE*GRID_SIDE cells through the read
// and write ports of the grid store; the result follows the pop, setup, walk and
// drain steps and the output register; input stalls meanwhile once the queue is full
// reset: synchronous; then a pass clears all GRID_SIDE*GRID_SIDE cells, no input
module rolling_occupancy_grid_unit #(
  parameter int GRID_SIDE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [15:0] center_x,
  input  logic signed [15:0] center_y,
  input  logic [5:0]         cell_x,
  input  logic [5:0]         cell_y,
  input  logic [1:0]         cell_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         read_value,
  output logic [6:0]         occupancy_percent,
  output logic               moved
);
  import rog_pkg::*;

  localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int CW = $clog2(GRID_SIDE);
  localparam int QW = AW + $bits(cmd_t);

  logic          init_done;
  logic          q_not_full;
  logic          q_not_empty;
  logic          q_push;
  logic          q_pop;
  cmd_t          f_cmd;
  logic [AW-1:0] f_idx;
  cmd_t          b_cmd;
  logic [AW-1:0] b_idx;
  logic [QW-1:0] q_head;

  // front: accept and classify requests
  rog_front #(
    .GRID_SIDE(GRID_SIDE),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .center_x(center_x),
    .center_y(center_y),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .cell_value(cell_value),
    .init_done(init_done),
    .q_not_full(q_not_full),
    .q_push(q_push),
    .q_cmd(f_cmd),
    .q_idx(f_idx)
  );

  // queue between front and back
  rog_cmd_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data({f_idx, f_cmd}),
    .not_full(q_not_full),
    .pop(q_pop),
    .not_empty(q_not_empty),
    .head(q_head)
  );

  assign b_idx = q_head[QW-1:$bits(cmd_t)];
  assign b_cmd = q_head[$bits(cmd_t)-1:0];

  // back: grid store, shift walk and result path
  rog_back #(
    .GRID_SIDE(GRID_SIDE),
    .AW(AW),
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .init_done(init_done),
    .q_not_empty(q_not_empty),
    .q_cmd(b_cmd),
    .q_idx(b_idx),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .occupancy_percent(occupancy_percent),
    .moved(moved)
  );

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rog_pkg::*;

  localparam int SIDE = 64;
  localparam int CELLS = SIDE * SIDE;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 500;
  localparam int DIRECTED_ROWS = 24;
  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef struct {
    logic [1:0]         mode;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [5:0]         x;
    logic [5:0]         y;
    logic [1:0]         val;
  } grid_req_t;

  typedef struct packed {
    logic [1:0] read_value;
    logic [6:0] occupancy_percent;
    logic       moved;
  } grid_resp_t;

  typedef struct {
    grid_req_t  req;
    bit         typed;
    grid_resp_t want;
  } grid_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         mode = MODE_READ;
  logic signed [15:0] center_x = '0;
  logic signed [15:0] center_y = '0;
  logic [5:0]         cell_x = '0;
  logic [5:0]         cell_y = '0;
  logic [1:0]         cell_value = CELL_UNKNOWN;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         read_value;
  logic [6:0]         occupancy_percent;
  logic               moved;

  // mirror of the grid store and the last center
  logic [1:0] grid_model [CELLS];
  logic [1:0] grid_snapshot [CELLS];
  int         model_cx = 0;
  int         model_cy = 0;

  grid_resp_t cell_results_due [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  bit         send_burst = 1'b0;
  grid_row_t  directed [DIRECTED_ROWS];

  rolling_occupancy_grid_unit i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .center_x          (center_x),
    .center_y          (center_y),
    .cell_x            (cell_x),
    .cell_y            (cell_y),
    .cell_value        (cell_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .read_value        (read_value),
    .occupancy_percent (occupancy_percent),
    .moved             (moved)
  );

  always #6 clk = ~clk;

  function automatic logic [6:0] cell_percent(input logic [1:0] s);
    case (s)
      CELL_FREE: return PCT_FREE;
      CELL_OCC:  return PCT_OCC;
      default:   return PCT_UNKNOWN;
    endcase
  endfunction

  // advance the grid mirror by one request and return its result
  function automatic grid_resp_t grid_apply(input grid_req_t r);
    grid_resp_t o;
    int dx, dy, sx, sy, idx;
    o = '0;
    case (r.mode)
      MODE_MOVE: begin
        if (int'(r.cx) != model_cx || int'(r.cy) != model_cy) begin
          dx = int'(r.cx) - model_cx;
          dy = int'(r.cy) - model_cy;
          model_cx = int'(r.cx);
          model_cy = int'(r.cy);
          grid_snapshot = grid_model;
          for (int yy = 0; yy < SIDE; yy++) begin
            for (int xx = 0; xx < SIDE; xx++) begin
              sx = xx + dx;
              sy = yy + dy;
              if (sx >= 0 && sx < SIDE && sy >= 0 && sy < SIDE)
                grid_model[yy * SIDE + xx] = grid_snapshot[sy * SIDE + sx];
              else
                grid_model[yy * SIDE + xx] = CELL_UNKNOWN;
            end
          end
          o.moved = 1'b1;
        end
      end
      MODE_WRITE, MODE_READ: begin
        o.occupancy_percent = PCT_UNKNOWN;
        if (int'(r.x) < SIDE && int'(r.y) < SIDE) begin
          idx = int'(r.y) * SIDE + int'(r.x);
          if (r.mode == MODE_WRITE)
            grid_model[idx] = (r.val == CELL_BAD) ? CELL_UNKNOWN : r.val;
          o.read_value = grid_model[idx];
          o.occupancy_percent = cell_percent(grid_model[idx]);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic grid_row_t step_row(input logic [1:0] m, input int cx, input int cy,
                                         input int x, input int y, input logic [1:0] v,
                                         input bit typed, input logic [1:0] rv,
                                         input logic [6:0] pct, input logic mv);
    grid_row_t row;
    row.req.mode = m;
    row.req.cx = 16'(cx);
    row.req.cy = 16'(cy);
    row.req.x = 6'(x);
    row.req.y = 6'(y);
    row.req.val = v;
    row.typed = typed;
    row.want = '{read_value: rv, occupancy_percent: pct, moved: mv};
    return row;
  endfunction

  task automatic note_mismatch(input string what, input grid_resp_t want, input grid_resp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch (%s): expected value %0d pct %0d moved %0d, got %0d %0d %0d",
               $realtime, what, want.read_value, want.occupancy_percent, want.moved,
               got.read_value, got.occupancy_percent, got.moved);
  endtask

  // present one request, hold it until taken, then predict its result
  task automatic issue(input grid_req_t r, input bit typed, input grid_resp_t typed_resp,
                       input bit hold_off);
    int gap;
    grid_resp_t due;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0 || hold_off) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (hold_off) begin
        do @(posedge clk); while (cell_results_due.size() != 0);
      end
    end
    in_valid   <= 1'b1;
    mode       <= r.mode;
    center_x   <= r.cx;
    center_y   <= r.cy;
    cell_x     <= r.x;
    cell_y     <= r.y;
    cell_value <= r.val;
    do @(posedge clk); while (in_ready !== 1'b1);
    due = grid_apply(r);
    cell_results_due.push_back(typed ? typed_resp : due);
  endtask

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, compare each result with the oldest prediction
  initial begin
    int stall;
    int taken;
    bit burst;
    grid_resp_t got;
    grid_resp_t want;
    taken = 0;
    burst = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 48 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
      got = {read_value, occupancy_percent, moved};
      if (cell_results_due.size() == 0) begin
        note_mismatch("result with nothing due", '0, got);
      end else begin
        want = cell_results_due.pop_front();
        if (got.read_value !== want.read_value ||
            got.occupancy_percent !== want.occupancy_percent ||
            got.moved !== want.moved)
          note_mismatch("field", want, got);
      end
    end
  end

  // stimulus
  initial begin
    grid_req_t r;
    int pick;
    bit window;
    foreach (grid_model[i]) grid_model[i] = CELL_UNKNOWN;

    // directed rows: cleared grid, extremes, bad write value, stay and shift moves
    directed[0]  = step_row(MODE_READ, 0, 0, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN,
                            PCT_UNKNOWN, 0);
    directed[1]  = step_row(MODE_READ, 0, 0, 63, 63, CELL_UNKNOWN, 1, CELL_UNKNOWN,
                            PCT_UNKNOWN, 0);
    directed[2]  = step_row(MODE_WRITE, 0, 0, 0, 0, CELL_FREE, 1, CELL_FREE, PCT_FREE, 0);
    directed[3]  = step_row(MODE_WRITE, 0, 0, 63, 63, CELL_OCC, 1, CELL_OCC, PCT_OCC, 0);
    directed[4]  = step_row(MODE_WRITE, 0, 0, 63, 0, CELL_BAD, 1, CELL_UNKNOWN,
                            PCT_UNKNOWN, 0);
    directed[5]  = step_row(MODE_WRITE, 0, 0, 0, 63, CELL_OCC, 1, CELL_OCC, PCT_OCC, 0);
    directed[6]  = step_row(MODE_WRITE, 0, 0, 0, 63, CELL_UNKNOWN, 1, CELL_UNKNOWN,
                            PCT_UNKNOWN, 0);
    directed[7]  = step_row(MODE_READ, 0, 0, 0, 0, CELL_UNKNOWN, 1, CELL_FREE, PCT_FREE, 0);
    directed[8]  = step_row(MODE_NOP, -1, -1, 63, 63, CELL_BAD, 1, CELL_UNKNOWN, PCT_FREE, 0);
    directed[9]  = step_row(MODE_MOVE, 0, 0, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN, PCT_FREE, 0);
    directed[10] = step_row(MODE_MOVE, 1, 1, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN, PCT_FREE, 1);
    directed[11] = step_row(MODE_READ, 0, 0, 62, 62, CELL_UNKNOWN, 0, '0, '0, 0);
    directed[12] = step_row(MODE_READ, 0, 0, 63, 63, CELL_UNKNOWN, 0, '0, '0, 0);
    directed[13] = step_row(MODE_MOVE, -32768, -32768, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN,
                            PCT_FREE, 1);
    directed[14] = step_row(MODE_READ, 0, 0, 62, 62, CELL_UNKNOWN, 0, '0, '0, 0);
    directed[15] = step_row(MODE_WRITE, 0, 0, 10, 20, CELL_OCC, 1, CELL_OCC, PCT_OCC, 0);
    directed[16] = step_row(MODE_MOVE, 32767, 32767, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN,
                            PCT_FREE, 1);
    directed[17] = step_row(MODE_MOVE, 32767, 32767, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN,
                            PCT_FREE, 0);
    directed[18] = step_row(MODE_WRITE, 0, 0, 5, 5, CELL_FREE, 1, CELL_FREE, PCT_FREE, 0);
    directed[19] = step_row(MODE_MOVE, 32766, 32767, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN,
                            PCT_FREE, 1);
    directed[20] = step_row(MODE_READ, 0, 0, 6, 5, CELL_UNKNOWN, 0, '0, '0, 0);
    directed[21] = step_row(MODE_MOVE, 32767, -32768, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN,
                            PCT_FREE, 1);
    directed[22] = step_row(MODE_NOP, 0, 0, 0, 0, CELL_UNKNOWN, 1, CELL_UNKNOWN, PCT_FREE, 0);
    directed[23] = step_row(MODE_READ, 0, 0, 6, 5, CELL_UNKNOWN, 0, '0, '0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      issue(directed[i].req, directed[i].typed, directed[i].want, 1'b0);

    // random part: mostly cell traffic in a small window, with a few moves
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      window = ($urandom_range(0, 9) < 7);
      r.x = window ? 6'(28 + $urandom_range(0, 7)) : 6'($urandom_range(0, 63));
      r.y = window ? 6'(28 + $urandom_range(0, 7)) : 6'($urandom_range(0, 63));
      r.val = 2'($urandom_range(0, 3));
      r.cx = 16'($urandom_range(0, 65535));
      r.cy = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        r.mode = MODE_MOVE;
        case ($urandom_range(0, 3))
          0: begin
            r.cx = 16'(model_cx);
            r.cy = 16'(model_cy);
          end
          1, 2: begin
            r.cx = 16'(model_cx + int'($urandom_range(0, 6)) - 3);
            r.cy = 16'(model_cy + int'($urandom_range(0, 6)) - 3);
          end
          default: ;
        endcase
      end else if (pick < 12) begin
        r.mode = MODE_NOP;
      end else if (pick < 60) begin
        r.mode = MODE_WRITE;
      end else begin
        r.mode = MODE_READ;
      end
      issue(r, 1'b0, '0, n == 0 || $urandom_range(0, 99) == 0);
    end

    in_valid <= 1'b0;
    while (cell_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ rolling_occupancy_grid_unit.f @@
rtl/core/rog_pkg.sv
rtl/core/rog_cmd_queue.sv
rtl/core/rog_front.sv
rtl/core/rog_back.sv
rtl/core/rolling_occupancy_grid_unit.sv
test/testbench.sv
